>>> hw/rtl/pwur_pkg.sv
package pwur_pkg;

   localparam int unsigned TicksWidth = 15;
   localparam int unsigned RemWidth   = TicksWidth + 1;
   localparam int unsigned PosWidth   = 4;

   localparam logic [PosWidth-1:0]   PosWait     = 4'd0;
   localparam logic [PosWidth-1:0]   PosStop     = 4'd9;
   localparam logic [PosWidth-1:0]   LastBitIdx  = 4'd8;
   localparam logic [TicksWidth-1:0] TpbReset    = 15'd100;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
      logic emit;
   } sts_type;

endpackage

>>> hw/rtl/pwur_datapath.sv
module pwur_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  pwur_pkg::cmd_type                  cmd,
   output pwur_pkg::sts_type                  sts,
   input  logic                               csr_wr_en,
   input  logic [pwur_pkg::TicksWidth-1:0]    csr_wr_data,
   input  logic [pwur_pkg::TicksWidth-1:0]    run_ticks,
   input  logic                               line_level,
   output logic [7:0]                         rx_byte
);
   import pwur_pkg::*;

   logic [TicksWidth-1:0] tpb_ff, tpb_in;
   logic [RemWidth-1:0]   rem_ff, rem_in;
   logic [PosWidth-1:0]   cnt_ff, cnt_in;
   logic                  all_ff, all_in;
   logic                  level_ff, level_in;
   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic [7:0]            shift_ff, shift_in;
   logic [7:0]            byte_ff, byte_in;

   logic [RemWidth-1:0]   tpb_wide;
   logic [RemWidth-1:0]   rem_after;
   logic                  more;

   assign tpb_wide  = {1'b0, tpb_ff};
   // remaining ticks after taking one bit time, floored at zero
   assign rem_after = (rem_ff >= tpb_wide) ? (rem_ff - tpb_wide) : '0;
   assign more      = (cnt_ff != LastBitIdx) && (all_ff || (rem_after >= tpb_wide));

   assign sts.emit = (pos_ff == PosStop) && level_ff;
   assign sts.last = (pos_ff == PosStop) || ((pos_ff == PosWait) && level_ff) || !more;
   assign rx_byte  = byte_ff;

   always_comb begin
      tpb_in   = tpb_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      all_in   = all_ff;
      level_in = level_ff;
      pos_in   = pos_ff;
      shift_in = shift_ff;
      byte_in  = byte_ff;
      if (csr_wr_en) begin
         tpb_in = csr_wr_data;
      end
      if (cmd.load) begin
         // round to nearest bit time by adding half a bit up front
         rem_in   = {1'b0, run_ticks} + {2'b0, tpb_ff[TicksWidth-1:1]};
         all_in   = (run_ticks == '0) || (tpb_ff == '0);
         level_in = line_level;
         cnt_in   = '0;
      end else if (cmd.step) begin
         rem_in = rem_after;
         cnt_in = cnt_ff + 4'd1;
         if (pos_ff == PosStop) begin
            pos_in = PosWait;
            if (level_ff) begin
               byte_in  = shift_ff;
               shift_in = '0;
            end
         end else if (pos_ff == PosWait) begin
            if (!level_ff) begin
               pos_in = 4'd1;
            end
         end else begin
            shift_in = {level_ff, shift_ff[7:1]};
            pos_in   = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff   <= TpbReset;
         pos_ff   <= PosWait;
         shift_ff <= '0;
      end else begin
         tpb_ff   <= tpb_in;
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      all_ff   <= all_in;
      level_ff <= level_in;
      byte_ff  <= byte_in;
   end

endmodule

>>> hw/rtl/pwur_controller.sv
module pwur_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pwur_pkg::cmd_type cmd,
   input  pwur_pkg::sts_type sts
);
   import pwur_pkg::*;

   localparam logic StIdle = 1'b0;
   localparam logic StRun  = 1'b1;

   logic state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic out_full;

   assign out_full  = out_valid_ff && !rsp_ready;
   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.step = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StRun;
            end
         end
         StRun: begin
            // hold a byte-producing bit until the output register frees up
            cmd.step = !(sts.emit && out_full);
            if (cmd.step && sts.last) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
      out_valid_in = out_full || (cmd.step && sts.emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> hw/rtl/pulse_width_uart_receiver_unit.sv
// an accepted item steps one line bit per cycle (save for the stall below), 1 to 9 bits;
// the single shared bit sequencer takes no new item until the last run is fully stepped,
// and a bit that completes a byte waits while the output is full
// reset: synchronous active high; clears the frame position and shift register,
// empties the output and loads ticks_per_bit with 100
module pulse_width_uart_receiver_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pwur_pkg::TicksWidth-1:0] req_run_ticks,
   input  logic                            req_line_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_rx_byte_out,
   input  logic                            csr_wr_en,
   input  logic [pwur_pkg::TicksWidth-1:0] csr_wr_data
);
   import pwur_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pwur_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pwur_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .run_ticks   (req_run_ticks),
      .line_level  (req_line_level),
      .rx_byte     (rsp_rx_byte_out)
   );

endmodule

>>> hw/rtl/pwur_checker.sv
module pwur_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_rx_byte_out
);

   // a stalled byte stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx_byte_out))
      else $error("stalled rsp item changed");

   // one run at a time: busy right after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while previous run in progress");

   // no bit is stepped in the accept cycle, so no new byte can appear next
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("byte produced in accept cycle");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

endmodule

bind pulse_width_uart_receiver_unit pwur_checker u_pwur_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_rx_byte_out (rsp_rx_byte_out)
);
